FILE: hdl/emaod_pkg.sv
// Shared constants, types and codes of the moving-average occupancy detector.
package emaod_pkg;

  // Sample and fixed-point format of the running average.
  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 8;
  localparam int AVG_W         = SAMPLE_BITS + FRACTION_BITS;

  // Configuration register widths.
  localparam int WEIGHT_BITS = 9;
  localparam int LEVEL_BITS  = 10;
  localparam int CFG_DATA_W  = (WEIGHT_BITS > LEVEL_BITS) ? WEIGHT_BITS : LEVEL_BITS;
  localparam int CFG_IDX_W   = 1;

  // Weight is in 1/WEIGHT_ONE units; WEIGHT_ONE is the top code that stays meaningful.
  localparam int WEIGHT_SHIFT = WEIGHT_BITS - 1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << WEIGHT_SHIFT);

  // Signed threshold width: average plus or minus the shifted level, with headroom.
  localparam int LVL_Q_W = LEVEL_BITS + FRACTION_BITS;
  localparam int THR_W   = ((AVG_W > LVL_Q_W) ? AVG_W : LVL_Q_W) + 2;

  // Reset values of the configuration registers.
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(32);
  localparam logic [LEVEL_BITS-1:0]  LEVEL_RESET  = LEVEL_BITS'(50);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL  = 1'b1;

  typedef enum logic [1:0] {
    PH_OPEN     = 2'd0,
    PH_COVERING = 2'd1,
    PH_COVERED  = 2'd2,
    PH_OPENING  = 2'd3
  } phase_e;

  // Result of one step, handed from the tracker to the output register.
  typedef struct packed {
    phase_e                 phase;
    logic                   changed;
    logic [SAMPLE_BITS-1:0] average;
  } step_res_t;

endpackage

FILE: hdl/emaod_average.sv
// Exponential moving average update: avg + w*(sample - avg)/256, rounded down.
module emaod_average (
  input  logic [emaod_pkg::AVG_W-1:0]       sample_q8_i,
  input  logic [emaod_pkg::AVG_W-1:0]       avg_q8_i,
  input  logic [emaod_pkg::WEIGHT_BITS-1:0] weight_i,
  output logic [emaod_pkg::AVG_W-1:0]       avg_q8_o
);
  import emaod_pkg::*;

  localparam int DIFF_W = AVG_W + 1;
  localparam int PROD_W = WEIGHT_BITS + 1 + DIFF_W;

  logic [WEIGHT_BITS-1:0]    w_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  w_ext;
  logic signed [PROD_W-1:0]  diff_ext;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  avg_scaled;
  logic signed [PROD_W-1:0]  mix;

  // Saturate the weight so the average never overshoots the sample.
  assign w_sat = (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;

  assign diff = $signed({1'b0, sample_q8_i}) - $signed({1'b0, avg_q8_i});
  // Extend both factors to the full product width before the multiply.
  assign w_ext    = $signed({{(PROD_W - WEIGHT_BITS){1'b0}}, w_sat});
  assign diff_ext = $signed({{(PROD_W - DIFF_W){diff[DIFF_W-1]}}, diff});
  assign prod     = w_ext * diff_ext;
  assign avg_scaled = $signed({{(PROD_W - AVG_W - WEIGHT_SHIFT){1'b0}}, avg_q8_i,
                               {WEIGHT_SHIFT{1'b0}}});
  // The blend lies between sample and average, so it is never negative.
  assign mix = avg_scaled + prod;

  assign avg_q8_o = mix[WEIGHT_SHIFT +: AVG_W];

endmodule

FILE: hdl/emaod_tracker.sv
// Detector state: running average, reference threshold, phase machine.
module emaod_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [emaod_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  logic                                busy_i,
  input  logic [emaod_pkg::WEIGHT_BITS-1:0]   weight_i,
  input  logic [emaod_pkg::LEVEL_BITS-1:0]    level_i,
  output emaod_pkg::step_res_t                res_o
);
  import emaod_pkg::*;

  phase_e                   phase_q, phase_d;
  logic [AVG_W-1:0]         avg_q, avg_d;
  logic signed [THR_W-1:0]  ref_q, ref_d;
  logic                     primed_q;

  logic [AVG_W-1:0]         sq;
  logic [AVG_W-1:0]         avg_mix;
  logic [AVG_W-1:0]         avg_new;
  logic signed [THR_W-1:0]  sq_s, avg_s, lvl_s, thr_hi, thr_lo;
  logic                     changed;

  assign sq = {sample_i, {FRACTION_BITS{1'b0}}};

  emaod_average u_average (
    .sample_q8_i (sq),
    .avg_q8_i    (avg_q),
    .weight_i    (weight_i),
    .avg_q8_o    (avg_mix)
  );

  // First sample after reset only loads the average.
  assign avg_new = primed_q ? avg_mix : sq;

  assign sq_s   = $signed({{(THR_W - AVG_W){1'b0}}, sq});
  assign avg_s  = $signed({{(THR_W - AVG_W){1'b0}}, avg_new});
  assign lvl_s  = $signed({{(THR_W - LVL_Q_W){1'b0}}, level_i, {FRACTION_BITS{1'b0}}});
  assign thr_hi = avg_s + lvl_s;
  assign thr_lo = avg_s - lvl_s;

  always_comb begin
    phase_d = phase_q;
    ref_d   = ref_q;
    avg_d   = avg_new;
    changed = 1'b0;
    unique case (phase_q)
      PH_OPEN: begin
        ref_d = thr_hi;
        if (primed_q && (sq_s > thr_hi)) begin
          phase_d = PH_COVERING;
        end
      end
      PH_COVERING: begin
        if (primed_q) begin
          if (sq_s < avg_s) begin
            phase_d = PH_OPEN;
          end else if ((avg_s > ref_q) && !busy_i) begin
            phase_d = PH_COVERED;
            changed = 1'b1;
            avg_d   = sq;
          end
        end
      end
      PH_COVERED: begin
        ref_d = thr_lo;
        if (primed_q && (sq_s < thr_lo)) begin
          phase_d = PH_OPENING;
        end
      end
      PH_OPENING: begin
        if (primed_q) begin
          if (sq_s > thr_hi) begin
            phase_d = PH_COVERED;
          end else if ((avg_s < ref_q) && !busy_i) begin
            phase_d = PH_OPEN;
            changed = 1'b1;
            avg_d   = sq;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPEN;
      avg_q    <= '0;
      ref_q    <= '0;
      primed_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      avg_q    <= avg_d;
      ref_q    <= ref_d;
      primed_q <= 1'b1;
    end
  end

  assign res_o.phase   = phase_d;
  assign res_o.changed = changed;
  assign res_o.average = avg_d[FRACTION_BITS +: SAMPLE_BITS];

endmodule

FILE: hdl/ema_occupancy_detector.sv
// An accepted sample passes the input stage, then the result register. The average update is
// one 10x19 multiply and an add per step. Throughput: one sample per cycle unless results stall.
// The result register frees the input side: a new sample is taken while a result waits.
// Reset (rst_ni low, asynchronous) clears the phase to open, the average, the reference
// and the primed flag, empties both stages, and loads weight 32 and level 50.
// Top level: input stage, configuration registers, tracker and result register.
module ema_occupancy_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [emaod_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  logic                                others_agree_busy_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          detector_state_o,
  output logic                                state_changed_o,
  output logic [emaod_pkg::SAMPLE_BITS-1:0]   average_value_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [emaod_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [emaod_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import emaod_pkg::*;

  // Configuration registers.
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [LEVEL_BITS-1:0]  level_q;

  // Input stage.
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_busy_q;

  // Result stage.
  logic                   out_valid_q;
  step_res_t              out_res_q;

  step_res_t              res;
  logic                   step;

  // Advance the input stage whenever the result register is empty or being drained.
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
      level_q  <= LEVEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SMOOTHING_WEIGHT: weight_q <= cfg_data_i[WEIGHT_BITS-1:0];
        CFG_THRESHOLD_LEVEL:  level_q  <= cfg_data_i[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture a transaction on the sample channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
      s1_busy_q   <= others_agree_busy_i;
    end
  end

  // Average, thresholds and phase update for the sample in the input stage.
  emaod_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (s1_sample_q),
    .busy_i   (s1_busy_q),
    .weight_i (weight_q),
    .level_i  (level_q),
    .res_o    (res)
  );

  // Result register: load on a step, drop once the consumer takes it, hold otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign detector_state_o = out_res_q.phase;
  assign state_changed_o  = out_res_q.changed;
  assign average_value_o  = out_res_q.average;

`ifndef SYNTH
  // A confirmed change only ever lands in covered or open.
  a_change_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && state_changed_o) |->
      (detector_state_o == PH_COVERED || detector_state_o == PH_OPEN))
    else $error("state change reported outside covered/open");

  // A confirmed change reloads the average from the sample itself.
  a_change_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.changed) |-> (res.average == s1_sample_q))
    else $error("average not reloaded on confirmed change");

  // Every step must leave a result waiting in the output register.
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("step did not produce a result");

  // The input stage must not advance onto a stalled result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !step)
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: tb/ema_occupancy_detector_checker.sv
`timescale 1ns / 100ps
// Checker of the occupancy detector: tracks settings, predicts each result and compares it.
module ema_occupancy_detector_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [emaod_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  logic                                others_agree_busy_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          detector_state_i,
  input  logic                                state_changed_i,
  input  logic [emaod_pkg::SAMPLE_BITS-1:0]   average_value_i,
  input  logic                                cfg_we_i,
  input  logic [emaod_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [emaod_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                  fail_cnt_o,
  output int                                  pending_o
);
  import emaod_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef logic signed [THR_W-1:0] thr_t;

  logic [WEIGHT_BITS-1:0] weight;
  logic [LEVEL_BITS-1:0]  level;
  phase_e                 phase;
  logic [AVG_W-1:0]       avg_q;
  thr_t                   thr_q;
  thr_t                   ref_q;
  logic                   primed;

  step_res_t predicted_steps_q[$];
  int        mismatch_cnt = 0;

  function automatic thr_t level_fixed();
    return thr_t'({level, {FRACTION_BITS{1'b0}}});
  endfunction

  // Threshold follows the phase; open and covered also latch the reference.
  function automatic void place_threshold();
    thr_t a;
    thr_t l;
    a = thr_t'(avg_q);
    l = level_fixed();
    case (phase)
      PH_OPEN: begin
        thr_q = a + l;
        ref_q = a + l;
      end
      PH_COVERING: thr_q = a + l;
      PH_COVERED: begin
        thr_q = a - l;
        ref_q = a - l;
      end
      default: thr_q = a - l;
    endcase
  endfunction

  function automatic step_res_t track_sample(input logic [SAMPLE_BITS-1:0] smp,
                                             input logic busy);
    logic [AVG_W-1:0]       smp_q;
    logic [WEIGHT_BITS-1:0] w;
    logic [31:0]            mix;
    thr_t                   s;
    thr_t                   a;
    logic                   changed;
    step_res_t              res;
    smp_q   = {smp, {FRACTION_BITS{1'b0}}};
    s       = thr_t'(smp_q);
    changed = 1'b0;
    if (!primed) begin
      // first sample only loads the average
      avg_q = smp_q;
      place_threshold();
      primed = 1'b1;
    end else begin
      w     = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      mix   = 32'(w) * 32'(smp_q) + 32'(WEIGHT_ONE - w) * 32'(avg_q);
      avg_q = AVG_W'(mix >> WEIGHT_SHIFT);
      place_threshold();
      a = thr_t'(avg_q);
      case (phase)
        PH_OPEN: begin
          if (s > thr_q) phase = PH_COVERING;
        end
        PH_COVERING: begin
          if (s < a) begin
            phase = PH_OPEN;
          end else if (a > ref_q && !busy) begin
            phase   = PH_COVERED;
            changed = 1'b1;
            avg_q   = smp_q;
            thr_q   = s - level_fixed();
          end
        end
        PH_COVERED: begin
          if (s < thr_q) phase = PH_OPENING;
        end
        default: begin
          if (s > a + level_fixed()) begin
            phase = PH_COVERED;
          end else if (a < ref_q && !busy) begin
            phase   = PH_OPEN;
            changed = 1'b1;
            avg_q   = smp_q;
            thr_q   = s + level_fixed();
          end
        end
      endcase
    end
    res.phase   = phase;
    res.changed = changed;
    res.average = avg_q[AVG_W-1:FRACTION_BITS];
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t exp_res;
    if (!rst_ni) begin
      weight = WEIGHT_RESET;
      level  = LEVEL_RESET;
      phase  = PH_OPEN;
      avg_q  = '0;
      thr_q  = '0;
      ref_q  = '0;
      primed = 1'b0;
      predicted_steps_q.delete();
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SMOOTHING_WEIGHT) begin
          weight = cfg_data_i[WEIGHT_BITS-1:0];
        end else if (cfg_index_i == CFG_THRESHOLD_LEVEL) begin
          level = cfg_data_i[LEVEL_BITS-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_steps_q.size() == 0) begin
          note_failure($sformatf("result with no sample pending: state %0d changed %0d avg %0d",
                                 detector_state_i, state_changed_i, average_value_i));
        end else begin
          exp_res = predicted_steps_q.pop_front();
          if (detector_state_i !== exp_res.phase || state_changed_i !== exp_res.changed ||
              average_value_i !== exp_res.average) begin
            note_failure($sformatf({"result mismatch: expected state %0d changed %0d avg %0d,",
                                    " got state %0d changed %0d avg %0d"},
                                   exp_res.phase, exp_res.changed, exp_res.average,
                                   detector_state_i, state_changed_i, average_value_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_steps_q.push_back(track_sample(sample_i, others_agree_busy_i));
      end
      pending_o  <= predicted_steps_q.size();
      fail_cnt_o <= mismatch_cnt;
    end
  end

endmodule

FILE: tb/ema_occupancy_detector_tb.sv
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, sample stimulus, result stalls and the verdict.
module ema_occupancy_detector_tb;
  import emaod_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 123;
  localparam int HOLD_PHASE   = 4;     // random phase that starts with the long receiver hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;    // two-stage pipeline, with some margin

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   busy = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             detector_state;
  logic                   state_changed;
  logic [SAMPLE_BITS-1:0] average_value;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_SMOOTHING_WEIGHT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_cnt;
  int pending;
  int cycle_cnt = 0;

  // Sender burst bookkeeping and the light-level walk of the random part.
  int   burst_left = 0;
  int   run_left = 0;
  int   target = 0;
  logic dark = 1'b0;

  // Set by the stimulus, taken by the receiver: one long stall of the result side.
  logic hold_off_req = 1'b0;

  always #CLK_HALF clk = ~clk;

  ema_occupancy_detector i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .sample_i            (sample),
    .others_agree_busy_i (busy),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .detector_state_o    (detector_state),
    .state_changed_o     (state_changed),
    .average_value_o     (average_value),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  ema_occupancy_detector_checker i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .sample_i            (sample),
    .others_agree_busy_i (busy),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .detector_state_i    (detector_state),
    .state_changed_i     (state_changed),
    .average_value_i     (average_value),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .fail_cnt_o          (fail_cnt),
    .pending_o           (pending)
  );

  // Offer one sample and hold it until the transaction completes. Bursts of
  // random length run back to back; between bursts valid may drop for a random gap.
  // Called at a rising edge; returns at the edge that accepted the sample.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic agree_busy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= smp;
    busy     <= agree_busy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out, then let
  // the pipeline settle so that a settings write lands on an idle block.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the weight register, then the level register; write enable stays high in between.
  task automatic write_settings(input int unsigned weight, input int unsigned level);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SMOOTHING_WEIGHT;
    cfg_data  <= CFG_DATA_W'(weight);
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD_LEVEL;
    cfg_data  <= CFG_DATA_W'(level);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Light level that alternates between dark and bright stretches of random
  // length, with sensor noise around the level and the odd wild reading.
  function automatic logic [SAMPLE_BITS-1:0] next_light();
    int v;
    if (run_left == 0) begin
      run_left = $urandom_range(2, 40);
      dark     = ~dark;
      target   = dark ? $urandom_range(0, 400) : $urandom_range(500, 1023);
    end
    run_left--;
    if ($urandom_range(0, 9) == 0) return SAMPLE_BITS'($urandom_range(0, 1023));
    v = target + int'($urandom_range(0, 60)) - 30;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_BITS'(v);
  endfunction

  // Stimulus: directed walk through the phases, then random phases under
  // different settings, then the verdict.
  initial begin : stimulus
    int unsigned weight;
    int unsigned level;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: prime, cover with the others busy then free, open with
    // the others busy then free, a covered dip back, and covering that falls back.
    send_sample(10'd100, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd0, 1'b1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd200, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1023, 1'b0);

    // Covered with an oversized weight and the top level: the average follows
    // the sample and the covered threshold goes below zero.
    drain();
    write_settings(300, 1023);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd512, 1'b0);

    // Zero weight and zero level: the average freezes, threshold equals it.
    drain();
    write_settings(0, 0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd0, 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin weight = 0;   level = 0;    end
        1:       begin weight = 511; level = 1023; end
        2:       begin weight = 256; level = 1;    end
        3:       begin weight = 1;   level = 512;  end
        9:       begin weight = $urandom_range(0, 511); level = $urandom_range(0, 1023); end
        default: begin weight = $urandom_range(4, 160); level = $urandom_range(5, 300); end
      endcase
      drain();
      write_settings(weight, level);
      // Ask the receiver for its long stall while samples keep coming.
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(next_light(), $urandom_range(0, 4) == 0);
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: ready follows a pattern that changes after a span of random length:
  // always ready, mostly ready, a fixed rhythm, or mostly stalled.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        if (hold_off_req) begin
          // Long stall: the result register and the input stage fill up and
          // the block has to push back on the sample side.
          hold_off_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ((tick % 3) != 0);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
        tick++;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
